[hw/rtl/okvt_pkg.sv]
// Shared types and constants for the ordered key-value table.
`timescale 1ns / 1ps

package okvt_pkg;

  localparam int ACTION_W    = 3;
  localparam int KEY_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 9;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 9;
  localparam int CAP_W       = 9;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP   = 3'd0,
    ACT_DEFINE   = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_READ_POS = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_INVALID   = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CAPACITY  = 1'b0,
    CFG_READ_ONLY = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POS_RD,
    S_POS_DATA,
    S_DONE
  } state_t;

endpackage

[hw/rtl/ordered_key_value_table.sv]
// Ordered key-value table: top level with scan and shift sequencer.
//
// Usage: one request word enters on the in_ channel (valid/stall) and exactly
// one result word leaves on the out_ channel (valid/stall). Actions are lookup,
// define, delete, clear and read by position; entries stay in insertion order.
// Keys and values live in two synchronous RAMs with a registered read port.
// A search reads and then compares each entry in turn from the first; a
// lookup or define stops at the first match, while a miss, append, full
// refusal or delete runs on to the last entry (a delete's scan and shift-down
// together visit every entry once). Clear, rejects and range errors go
// straight to the result, read by position reads the RAMs and then loads the
// result; the block accepts again in the cycle after the result is loaded.
// One request is in flight at a time; the next request is taken as soon as
// the previous result sits in the output register, even if it is not taken.
// If the receiver stalls and the output register is full, the finished result
// waits inside and no new request is accepted. Configuration writes on the
// cfg_ port are always ready and are meant for idle periods only.
// Reset empties the table, sets capacity_in_use to 256 and clears read_only;
// no pass over the RAMs is needed since only entries below the count are read.
`timescale 1ns / 1ps

module ordered_key_value_table
  import okvt_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ACTION_W-1:0]    in_action,
  input  logic [KEY_W-1:0]       in_key,
  input  logic [VALUE_W-1:0]     in_value,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    out_status,
  output logic                   out_found,
  output logic [KEY_W-1:0]       out_key_out,
  output logic [VALUE_W-1:0]     out_value_out,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     idx_plus1;
  status_t              status_r, status_nxt;
  logic                 found_r, found_nxt;
  logic [KEY_W-1:0]     kout_r, kout_nxt;
  logic [VALUE_W-1:0]   vout_r, vout_nxt;

  action_t              act_r;
  logic [KEY_W-1:0]     key_r;
  logic [VALUE_W-1:0]   val_r;

  logic [CAP_W-1:0]     cap_r;
  logic                 ro_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_found_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic [CNT_W-1:0]     out_count_r;

  logic                 in_accept;
  logic                 out_free;
  logic                 table_full;
  logic [CMP_W-1:0]     count_cmp;
  logic [CMP_W-1:0]     pos_cmp;

  logic                 key_we, val_we;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [KEY_W-1:0]     key_wdata, key_rdata;
  logic [VALUE_W-1:0]   val_wdata, val_rdata;

  okvt_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  okvt_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign in_accept       = in_valid && !in_stall;
  assign out_free        = !out_valid_r || !out_stall;
  assign cfg_ready       = 1'b1;
  assign count_cmp       = CMP_W'(count_r);
  assign pos_cmp         = CMP_W'(in_position);
  assign idx_plus1       = idx_r + CNT_W'(1);
  // The limit is the smaller of the capacity register and the RAM depth.
  assign table_full      = (count_cmp >= CMP_W'(cap_r)) || (count_cmp >= MAX_CMP);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_key_out     = out_key_r;
  assign out_value_out   = out_value_r;
  assign out_entry_count = COUNT_OUT_W'(out_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    kout_r   <= kout_nxt;
    vout_r   <= vout_nxt;
    if (in_accept) begin
      act_r <= action_t'(in_action);
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      ro_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_CAPACITY:  cap_r <= cfg_wdata;
        CFG_READ_ONLY: ro_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_key_r    <= kout_r;
      out_value_r  <= vout_r;
      out_count_r  <= count_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    kout_nxt   = kout_r;
    vout_nxt   = vout_r;
    key_we     = 1'b0;
    val_we     = 1'b0;
    waddr      = idx_r[IDX_W-1:0];
    raddr      = idx_r[IDX_W-1:0];
    key_wdata  = key_r;
    val_wdata  = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          kout_nxt   = '0;
          vout_nxt   = '0;
          idx_nxt    = '0;
          case (action_t'(in_action))
            ACT_LOOKUP: state_nxt = S_SCAN_RD;
            ACT_DEFINE, ACT_DELETE: begin
              if (ro_r) begin
                status_nxt = ST_INVALID;
                state_nxt  = S_DONE;
              end else begin
                state_nxt  = S_SCAN_RD;
              end
            end
            ACT_CLEAR: begin
              if (ro_r) begin
                status_nxt = ST_INVALID;
              end else begin
                count_nxt  = '0;
              end
              state_nxt = S_DONE;
            end
            ACT_READ_POS: begin
              if (pos_cmp == '0 || pos_cmp > count_cmp) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt    = CNT_W'(pos_cmp - CMP_W'(1));
                state_nxt  = S_POS_RD;
              end
            end
            default: begin
              status_nxt = ST_INVALID;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          // Scan ran past the last entry without a match.
          state_nxt = S_DONE;
          case (act_r)
            ACT_DEFINE: begin
              if (table_full) begin
                status_nxt = ST_FULL;
              end else begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                waddr     = count_r[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            default: status_nxt = ST_NOT_FOUND;
          endcase
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (key_rdata == key_r) begin
          case (act_r)
            ACT_LOOKUP: begin
              found_nxt = 1'b1;
              vout_nxt  = val_rdata;
              state_nxt = S_DONE;
            end
            ACT_DEFINE: begin
              val_we    = 1'b1;
              state_nxt = S_DONE;
            end
            default: begin
              found_nxt = 1'b1;
              state_nxt = S_SHIFT_RD;
            end
          endcase
        end else begin
          idx_nxt   = idx_plus1;
          state_nxt = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_plus1 == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          raddr     = idx_plus1[IDX_W-1:0];
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        key_we    = 1'b1;
        val_we    = 1'b1;
        key_wdata = key_rdata;
        val_wdata = val_rdata;
        idx_nxt   = idx_plus1;
        state_nxt = S_SHIFT_RD;
      end

      S_POS_RD: state_nxt = S_POS_DATA;

      S_POS_DATA: begin
        kout_nxt  = key_rdata;
        vout_nxt  = val_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> (CNT_W'(waddr) <= count_r))
    else $error("key write beyond the end of the table");

  a_shift_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_WR) |-> (idx_plus1 < count_r))
    else $error("shift write past the last entry");

  a_count_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_accept) |=> $stable(count_r))
    else $error("entry count changed with no word in flight");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && found_r) |-> (status_r == ST_OK))
    else $error("found flag set with an error status");

endmodule

[hw/rtl/okvt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module okvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
